// ===== rtl/core/qte_pkg.sv =====
package qte_pkg;

    // CORDIC micro-rotations, 8 .. 24
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;

    // vector, angle and wrapped-angle widths
    localparam int CW = 36;
    localparam int ZW = 24;
    localparam int YW = 26;

    // square root: radicand, working and root widths
    localparam int RAD_W   = 61;
    localparam int SQW     = 63;
    localparam int ROOT_W  = 31;
    localparam int ISQ_LAT = (SQW + 1) / 2;

    // alignment of the three angle paths
    localparam int PITCH_DONE = 4 + ISQ_LAT + CORDIC_LAT;
    localparam int S_DLY      = 2 + ISQ_LAT;
    localparam int CODE_DLY   = 2 + ISQ_LAT + CORDIC_LAT;
    localparam int CODE_TAP   = CORDIC_LAT - 1;
    localparam int ROLL_DLY   = 1 + ISQ_LAT;
    localparam int YAW_DLY    = ISQ_LAT;

    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [YW-1:0] PI_Q20      = 26'sd3294199;
    localparam logic signed [YW-1:0] TWO_PI_Q20  = 26'sd6588398;
    localparam logic signed [15:0]   ANG_LIM     = 16'sd25736;
    localparam logic signed [15:0]   PITCH_LIM16 = 16'sd12868;
    localparam logic signed [14:0]   PITCH_LIM   = 15'sd12868;
    localparam logic signed [31:0]   ONE_Q30     = 32'sd1073741824;
    localparam logic [14:0]          THR_RESET   = 15'd16351;

    typedef enum logic [1:0] {
        CODE_REGULAR   = 2'd0,
        CODE_PITCH_NEG = 2'd1,
        CODE_PITCH_POS = 2'd2
    } sing_code_t;

    // atan(2^-i) at 2^20 per radian
    function automatic logic signed [ZW-1:0] atan_q20(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 24'sd823550;
            1:       a = 24'sd486170;
            2:       a = 24'sd256879;
            3:       a = 24'sd130396;
            4:       a = 24'sd65451;
            5:       a = 24'sd32757;
            6:       a = 24'sd16383;
            7:       a = 24'sd8192;
            8:       a = 24'sd4096;
            9:       a = 24'sd2048;
            10:      a = 24'sd1024;
            11:      a = 24'sd512;
            12:      a = 24'sd256;
            13:      a = 24'sd128;
            14:      a = 24'sd64;
            15:      a = 24'sd32;
            16:      a = 24'sd16;
            17:      a = 24'sd8;
            18:      a = 24'sd4;
            19:      a = 24'sd2;
            20:      a = 24'sd1;
            default: a = 24'sd0;
        endcase
        return a;
    endfunction

    // round 2^20 angle to 2^13 and clamp to +-lim
    function automatic logic signed [15:0] to_out(input logic signed [YW-1:0] z,
                                                  input logic signed [15:0] lim);
        logic signed [YW-1:0] r;
        logic signed [YW-1:0] l;
        logic signed [15:0]   o;
        r = (z + YW'(64)) >>> 7;
        l = YW'(lim);
        if (r > l)
            o = lim;
        else if (r < -l)
            o = -lim;
        else
            o = r[15:0];
        return o;
    endfunction

endpackage

// ===== rtl/core/qte_cordic.sv =====
module qte_cordic
    import qte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    output logic                 valid_out,
    output logic signed [ZW-1:0] z_out
);

    logic signed [CW-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CW-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STEPS];
    logic                 zero_reg [0:CORDIC_STEPS];
    logic                 vld_reg [0:CORDIC_STEPS];

    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    // quadrant fold into the right half plane
    always_comb
    begin
        x_next = x_in;
        y_next = y_in;
        z_next = '0;
        if (x_in[CW-1])
        begin
            if (!y_in[CW-1])
            begin
                x_next = y_in;
                y_next = -x_in;
                z_next = HALF_PI_Q20;
            end
            else
            begin
                x_next = -y_in;
                y_next = x_in;
                z_next = -HALF_PI_Q20;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_next;
        y_reg[0]    <= y_next;
        z_reg[0]    <= z_next;
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (!y_reg[i][CW-1])
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_q20(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_q20(i);
            end
        end
    end

    assign valid_out = vld_reg[CORDIC_STEPS];
    // atan2(0,0) is 0
    assign z_out = zero_reg[CORDIC_STEPS] ? '0 : z_reg[CORDIC_STEPS];

endmodule

// ===== rtl/core/qte_isqrt.sv =====
module qte_isqrt
    import qte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  logic [RAD_W-1:0]  radicand,
    output logic              valid_out,
    output logic [ROOT_W-1:0] root
);

    logic [SQW-1:0] n_reg [0:ISQ_LAT-1];
    logic [SQW-1:0] r_reg [0:ISQ_LAT-1];
    logic           vld_reg [0:ISQ_LAT-1];

    // one root bit per stage, restoring
    for (genvar k = 0; k < ISQ_LAT; k++)
    begin : g_bit
        localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 1 - 2 * k);
        logic [SQW-1:0] n_in;
        logic [SQW-1:0] r_in;
        logic           v_in;
        logic [SQW-1:0] trial;

        if (k == 0)
        begin : g_first
            assign n_in = SQW'(radicand);
            assign r_in = '0;
            assign v_in = valid_in;
        end
        else
        begin : g_next
            assign n_in = n_reg[k-1];
            assign r_in = r_reg[k-1];
            assign v_in = vld_reg[k-1];
        end

        assign trial = r_in + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (n_in >= trial)
            begin
                n_reg[k] <= n_in - trial;
                r_reg[k] <= (r_in >> 1) + BIT;
            end
            else
            begin
                n_reg[k] <= n_in;
                r_reg[k] <= r_in >> 1;
            end
        end
    end

    assign valid_out = vld_reg[ISQ_LAT-1];
    assign root      = r_reg[ISQ_LAT-1][ROOT_W-1:0];

endmodule

// ===== rtl/core/quaternion_to_euler_angles.sv =====
// Quaternion (Q1.15) to Z-Y-X Euler angles at 8192 per radian, with a gimbal-lock
// code. A quaternion is taken at every clock edge where start is high; busy is
// always low, so a transfer can be offered every cycle. The result appears on
// the output ports with done high for exactly one cycle. When it appears is set
// by the pitch path: product and square stages, a 32-stage bit-per-stage
// square root, then a CORDIC of CORDIC_STEPS + 1 stages. The receiver cannot
// stall the block, so results must be taken as they come. The threshold
// register may only be written while no transfer is in flight.
module quaternion_to_euler_angles
    import qte_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic               cfg_wr_en,
    input  logic [14:0]        cfg_wr_data,
    output logic               done,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic [1:0]         singular_code
);

    // threshold register
    logic [14:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (cfg_wr_en)
            thr_reg <= cfg_wr_data;
    end

    // never stalls
    assign busy = 1'b0;

    // stage 1: all products at 2^-30
    logic               v1_reg;
    logic signed [31:0] p00_reg, p11_reg, p22_reg, p33_reg;
    logic signed [31:0] p02_reg, p13_reg, p23_reg, p01_reg, p12_reg, p03_reg;
    logic signed [15:0] q0_reg, q1_reg;
    logic [14:0]        thr1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        p00_reg  <= quat_w * quat_w;
        p11_reg  <= quat_x * quat_x;
        p22_reg  <= quat_y * quat_y;
        p33_reg  <= quat_z * quat_z;
        p02_reg  <= quat_w * quat_y;
        p13_reg  <= quat_x * quat_z;
        p23_reg  <= quat_y * quat_z;
        p01_reg  <= quat_w * quat_x;
        p12_reg  <= quat_x * quat_y;
        p03_reg  <= quat_w * quat_z;
        q0_reg   <= quat_w;
        q1_reg   <= quat_x;
        thr1_reg <= thr_reg;
    end

    // stage 2: gimbal test, CORDIC vectors, saturated asin argument
    logic signed [32:0]   c_val;
    logic signed [32:0]   thr_val;
    logic signed [33:0]   neg2c;
    logic signed [33:0]   roll_y, roll_x, yaw_y, yaw_x;
    sing_code_t           code_next;
    logic signed [31:0]   s_next;
    logic signed [CW-1:0] yaw_y_next, yaw_x_next;

    always_comb
    begin
        c_val   = 33'(p02_reg) + 33'(p13_reg);
        thr_val = $signed({3'b000, thr1_reg, 15'b0});
        neg2c   = -(34'(c_val) <<< 1);
        roll_y  = (34'(p23_reg) - 34'(p01_reg)) <<< 1;
        roll_x  = 34'(p00_reg) - 34'(p11_reg) - 34'(p22_reg) + 34'(p33_reg);
        yaw_y   = (34'(p12_reg) - 34'(p03_reg)) <<< 1;
        yaw_x   = 34'(p00_reg) + 34'(p11_reg) - 34'(p22_reg) - 34'(p33_reg);

        if (c_val > thr_val)
            code_next = CODE_PITCH_NEG;
        else if (c_val < -thr_val)
            code_next = CODE_PITCH_POS;
        else
            code_next = CODE_REGULAR;

        if (neg2c > 34'(ONE_Q30))
            s_next = ONE_Q30;
        else if (neg2c < -34'(ONE_Q30))
            s_next = -ONE_Q30;
        else
            s_next = neg2c[31:0];

        // singular case: yaw CORDIC works on (q1, q0) instead
        if (code_next != CODE_REGULAR)
        begin
            yaw_y_next = CW'(q1_reg) <<< 15;
            yaw_x_next = CW'(q0_reg) <<< 15;
        end
        else
        begin
            yaw_y_next = CW'(yaw_y);
            yaw_x_next = CW'(yaw_x);
        end
    end

    logic                 v2_reg;
    sing_code_t           code2_reg;
    logic signed [31:0]   s2_reg;
    logic signed [CW-1:0] roll_y_reg, roll_x_reg, yaw_y_reg, yaw_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        code2_reg  <= code_next;
        s2_reg     <= s_next;
        roll_y_reg <= CW'(roll_y);
        roll_x_reg <= CW'(roll_x);
        yaw_y_reg  <= yaw_y_next;
        yaw_x_reg  <= yaw_x_next;
    end

    // stages 3 and 4: radicand 1 - s^2 at 2^-60
    logic               v3_reg, v4_reg;
    logic signed [63:0] s_sq;
    logic [RAD_W-1:0]   ssq_reg;
    logic [RAD_W-1:0]   rad_reg;

    assign s_sq = s2_reg * s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ssq_reg <= s_sq[RAD_W-1:0];
        rad_reg <= (RAD_W'(1) << (RAD_W - 1)) - ssq_reg;
    end

    // delay lines for code and asin argument
    sing_code_t         code_dly_reg [0:CODE_DLY-1];
    logic signed [31:0] s_dly_reg [0:S_DLY-1];

    always_ff @(posedge clk)
    begin
        code_dly_reg[0] <= code2_reg;
        for (int k = 1; k < CODE_DLY; k++)
            code_dly_reg[k] <= code_dly_reg[k-1];
        s_dly_reg[0] <= s2_reg;
        for (int k = 1; k < S_DLY; k++)
            s_dly_reg[k] <= s_dly_reg[k-1];
    end

    // roll and yaw CORDICs
    logic                 roll_vld, yaw_vld;
    logic signed [ZW-1:0] roll_z, yaw_z;

    qte_cordic u_roll_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v2_reg),
        .x_in      (roll_x_reg),
        .y_in      (roll_y_reg),
        .valid_out (roll_vld),
        .z_out     (roll_z)
    );

    qte_cordic u_yaw_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v2_reg),
        .x_in      (yaw_x_reg),
        .y_in      (yaw_y_reg),
        .valid_out (yaw_vld),
        .z_out     (yaw_z)
    );

    // yaw: doubling for singular items, wrap into +-pi, then round
    sing_code_t           yaw_code;
    logic signed [YW-1:0] yaw_ext, yaw_dbl, yaw_wrap;
    logic signed [YW-1:0] yaw_w_reg;
    logic signed [15:0]   yaw_o_reg;
    logic signed [15:0]   roll_o_reg;

    assign yaw_code = code_dly_reg[CODE_TAP];

    always_comb
    begin
        yaw_ext = YW'(yaw_z);
        case (yaw_code)
            CODE_PITCH_NEG: yaw_dbl = -(yaw_ext <<< 1);
            CODE_PITCH_POS: yaw_dbl = yaw_ext <<< 1;
            default:        yaw_dbl = yaw_ext;
        endcase
        if (yaw_dbl > PI_Q20)
            yaw_wrap = yaw_dbl - TWO_PI_Q20;
        else if (yaw_dbl < -PI_Q20)
            yaw_wrap = yaw_dbl + TWO_PI_Q20;
        else
            yaw_wrap = yaw_dbl;
    end

    always_ff @(posedge clk)
    begin
        yaw_w_reg  <= yaw_wrap;
        yaw_o_reg  <= to_out(yaw_w_reg, ANG_LIM);
        roll_o_reg <= to_out(YW'(roll_z), ANG_LIM);
    end

    // hold roll and yaw until pitch catches up
    logic signed [15:0] roll_dly_reg [0:ROLL_DLY-1];
    logic signed [15:0] yaw_dly_reg [0:YAW_DLY-1];

    always_ff @(posedge clk)
    begin
        roll_dly_reg[0] <= roll_o_reg;
        for (int k = 1; k < ROLL_DLY; k++)
            roll_dly_reg[k] <= roll_dly_reg[k-1];
        yaw_dly_reg[0] <= yaw_o_reg;
        for (int k = 1; k < YAW_DLY; k++)
            yaw_dly_reg[k] <= yaw_dly_reg[k-1];
    end

    // pitch: asin(s) = atan2(s, sqrt(1 - s^2))
    logic              sq_vld;
    logic [ROOT_W-1:0] cs_root;

    qte_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v4_reg),
        .radicand  (rad_reg),
        .valid_out (sq_vld),
        .root      (cs_root)
    );

    logic                 pitch_vld;
    logic signed [ZW-1:0] pitch_z;

    qte_cordic u_pitch_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sq_vld),
        .x_in      ($signed(CW'(cs_root))),
        .y_in      (CW'(s_dly_reg[S_DLY-1])),
        .valid_out (pitch_vld),
        .z_out     (pitch_z)
    );

    // output register
    sing_code_t         out_code;
    logic signed [15:0] pitch_full;
    logic               done_reg;
    logic signed [15:0] roll_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] yaw_reg;
    sing_code_t         code_reg;

    assign out_code   = code_dly_reg[CODE_DLY-1];
    assign pitch_full = to_out(YW'(pitch_z), PITCH_LIM16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= pitch_vld;
    end

    always_ff @(posedge clk)
    begin
        code_reg <= out_code;
        yaw_reg  <= yaw_dly_reg[YAW_DLY-1];
        case (out_code)
            CODE_PITCH_NEG:
            begin
                roll_reg  <= '0;
                pitch_reg <= -PITCH_LIM;
            end
            CODE_PITCH_POS:
            begin
                roll_reg  <= '0;
                pitch_reg <= PITCH_LIM;
            end
            default:
            begin
                roll_reg  <= roll_dly_reg[ROLL_DLY-1];
                pitch_reg <= pitch_full[14:0];
            end
        endcase
    end

    assign done          = done_reg;
    assign roll_angle    = roll_reg;
    assign pitch_angle   = pitch_reg;
    assign yaw_angle     = yaw_reg;
    assign singular_code = code_reg;

    // checks
    a_ry_align: assert property (@(posedge clk) disable iff (!rst_n)
        roll_vld == yaw_vld)
        else $error("roll and yaw CORDIC valids out of step");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(PITCH_DONE + 1) done)
        else $error("accepted transfer did not complete on time");

    a_sing_roll: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular_code != CODE_REGULAR) |-> roll_angle == 16'sd0)
        else $error("singular result with nonzero roll");

    a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pitch_angle <= PITCH_LIM && pitch_angle >= -PITCH_LIM))
        else $error("pitch out of range");

    a_pitch_neg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular_code == CODE_PITCH_NEG) |-> pitch_angle == -PITCH_LIM)
        else $error("forced pitch wrong");

endmodule

// ===== dv/quaternion_to_euler_angles_test.sv =====
module quaternion_to_euler_angles_test;
    import qte_pkg::*;

    // Bench-side bounds: the run limit and the settle time after the last
    // result.
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 80;
    localparam int N_RANDOM     = 1530;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        sing_code_t         code;
    } euler_t;

    // Keeps its own copy of the threshold and a queue of predicted angle sets.
    class euler_scoreboard;
        logic [14:0] threshold;
        euler_t      angles_due[$];
        int          errors;

        // atan(2^-i) at 2^20 per radian
        longint atan_steps[24] = '{823550, 486170, 256879, 130396, 65451, 32757,
                                   16383, 8192, 4096, 2048, 1024, 512, 256, 128,
                                   64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

        function new();
            threshold = THR_RESET;
            errors    = 0;
        endfunction

        function longint vector_angle(longint y_in, longint x_in);
            longint x, y, z, t, xs, ys;
            x = x_in;
            y = y_in;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            // pre-rotate the left half-plane by a quarter turn
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = 1647099;
                end
                else begin
                    t = x; x = -y; y = t; z = -1647099;
                end
            end
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z += atan_steps[i];
                end
                else begin
                    x = x - ys; y = y + xs; z -= atan_steps[i];
                end
            end
            return z;
        endfunction

        function longint round_clamp(longint z, longint lim);
            longint r;
            r = (z + 64) >>> 7;
            if (r > lim)
                return lim;
            if (r < -lim)
                return -lim;
            return r;
        endfunction

        function longint wrap_angle(longint z);
            if (z > 3294199)
                return z - 6588398;
            if (z < -3294199)
                return z + 6588398;
            return z;
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n  -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        function void note_quat(logic signed [15:0] w, logic signed [15:0] x,
                                logic signed [15:0] y, logic signed [15:0] z);
            longint q0, q1, q2, q3, c, thr, s, cs;
            euler_t e;
            q0  = w; q1 = x; q2 = y; q3 = z;
            c   = q0 * q2 + q1 * q3;
            thr = longint'(threshold) * 32768;
            if (c > thr) begin
                e.code  = CODE_PITCH_NEG;
                e.roll  = 0;
                e.pitch = -15'sd12868;
                e.yaw   = 16'(round_clamp(wrap_angle(-2 * vector_angle(q1 * 32768,
                                           q0 * 32768)), 25736));
            end
            else if (c < -thr) begin
                e.code  = CODE_PITCH_POS;
                e.roll  = 0;
                e.pitch = 15'sd12868;
                e.yaw   = 16'(round_clamp(wrap_angle(2 * vector_angle(q1 * 32768,
                                           q0 * 32768)), 25736));
            end
            else begin
                e.code  = CODE_REGULAR;
                e.roll  = 16'(round_clamp(vector_angle(2 * (q2 * q3 - q0 * q1),
                              q0 * q0 - q1 * q1 - q2 * q2 + q3 * q3), 25736));
                s = -2 * c;
                if (s > 64'sd1073741824)
                    s = 64'sd1073741824;
                if (s < -64'sd1073741824)
                    s = -64'sd1073741824;
                cs = longint'(int_root((64'd1 << 60) - longint'(s * s)));
                e.pitch = 15'(round_clamp(vector_angle(s, cs), 12868));
                e.yaw   = 16'(round_clamp(wrap_angle(vector_angle(2 * (q1 * q2 - q0 * q3),
                              q0 * q0 + q1 * q1 - q2 * q2 - q3 * q3)), 25736));
            end
            angles_due.push_back(e);
        endfunction

        function void check_angles(euler_t got);
            euler_t want;
            if (angles_due.size() == 0) begin
                $error("unexpected result: roll %0d pitch %0d yaw %0d code %0d",
                       got.roll, got.pitch, got.yaw, got.code);
                errors++;
                return;
            end
            want = angles_due.pop_front();
            if (got.roll !== want.roll) begin
                $error("roll_angle: expected %0d, got %0d", want.roll, got.roll);
                errors++;
            end
            if (got.pitch !== want.pitch) begin
                $error("pitch_angle: expected %0d, got %0d", want.pitch, got.pitch);
                errors++;
            end
            if (got.yaw !== want.yaw) begin
                $error("yaw_angle: expected %0d, got %0d", want.yaw, got.yaw);
                errors++;
            end
            if (got.code !== want.code) begin
                $error("singular_code: expected %0d, got %0d", want.code, got.code);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] quat_w = '0;
    logic signed [15:0] quat_x = '0;
    logic signed [15:0] quat_y = '0;
    logic signed [15:0] quat_z = '0;
    logic               cfg_wr_en = 1'b0;
    logic [14:0]        cfg_wr_data = '0;
    logic               done;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic [1:0]         singular_code;

    euler_scoreboard sb = new();
    int              cycles = 0;
    int              idle_pct = 0;

    always #5 clk = ~clk;

    quaternion_to_euler_angles dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .quat_w        (quat_w),
        .quat_x        (quat_x),
        .quat_y        (quat_y),
        .quat_z        (quat_z),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .done          (done),
        .roll_angle    (roll_angle),
        .pitch_angle   (pitch_angle),
        .yaw_angle     (yaw_angle),
        .singular_code (singular_code)
    );

    // Transfers in and results out are both taken at the rising edge; inputs
    // only move on the falling edge, so the sampled values are stable.
    always @(posedge clk)
    begin
        euler_t got;
        if (rst_n && start && !busy)
            sb.note_quat(quat_w, quat_x, quat_y, quat_z);
        if (rst_n && done) begin
            got.roll  = roll_angle;
            got.pitch = pitch_angle;
            got.yaw   = yaw_angle;
            got.code  = sing_code_t'(singular_code);
            sb.check_angles(got);
        end
    end

    // Run limit, generous against the slowest legal run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // One transfer: hold start until accepted, then maybe leave a gap.
    task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z);
        @(negedge clk);
        start  <= 1'b1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
    endtask

    // Lower start and let every outstanding result come home.
    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (sb.angles_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write, only ever issued once the pipe is empty.
    task automatic write_threshold(input logic [14:0] thr);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.threshold = thr;
    endtask

    // Random quaternion: full-range, reduced-range or small values, or a near
    // gimbal-lock shape (q0 ~ +-q2 with small q1/q3, or the q1/q3 pairing)
    // that straddles the threshold.
    task automatic send_random;
        logic signed [15:0] a, b, n1, n2;
        int                 mode;
        mode = $urandom_range(9);
        a    = 16'($urandom_range(32767));
        b    = 16'($urandom);
        n1   = 16'($signed(10'($urandom)));
        n2   = 16'($signed(10'($urandom)));
        case (mode)
            0, 1, 2, 3:
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            4:
                send_quat(16'($signed(8'($urandom))), 16'($signed(8'($urandom))),
                          16'($signed(8'($urandom))), 16'($signed(8'($urandom))));
            5, 6:
                send_quat(a, n1, $urandom_range(1) ? a + n2 : -a + n2, b >>> 3);
            7:
                send_quat(b >>> 2, a, n1, $urandom_range(1) ? a + n2 : -a + n2);
            default:
                send_quat(16'($urandom_range(23170)) , 16'($signed(15'($urandom))),
                          16'($signed(15'($urandom))), 16'($signed(14'($urandom))));
        endcase
    endtask

    initial
    begin
        logic [14:0] thr_set[5];
        thr_set = '{15'd0, 15'd16384, 15'd32767, 15'd8000, 15'd16351};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: identity, zero vector, field extremes, both gimbal locks,
        // yaw wrap and negative scalar parts, all at the reset threshold.
        send_quat(16'sd32767, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(-16'sd32768, 0, 0, 0);
        send_quat(0, 16'sd32767, 0, 0);
        send_quat(0, 0, 16'sd32767, 0);
        send_quat(0, 0, 0, 16'sd32767);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_quat(16'sd23170, 0, 16'sd23170, 0);
        send_quat(16'sd23170, 0, -16'sd23170, 0);
        send_quat(16'sd23170, 16'sd23170, 0, 0);
        send_quat(16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384);
        send_quat(-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);
        send_quat(-16'sd32768, 16'sd100, 0, 0);
        send_quat(-16'sd32768, -16'sd100, 0, 0);
        send_quat(-16'sd20000, 16'sd5000, 16'sd23000, -16'sd1000);
        send_quat(16'sd100, 16'sd30000, -16'sd200, 16'sd9000);
        send_quat(16'sd23169, 16'sd1, 16'sd23169, 16'sd1);
        drain();

        // Threshold of zero: c = 0 stays regular, anything else is singular.
        write_threshold(15'd0);
        send_quat(16'sd32767, 0, 0, 0);
        send_quat(16'sd1000, 16'sd1, 0, 0);
        send_quat(16'sd1000, 0, 16'sd1, 0);
        send_quat(16'sd1000, 0, -16'sd1, 0);
        drain();

        // Random part in three idling phases, threshold changed between
        // chunks; each chunk drains first, so the sender waits for all results.
        for (int k = 0; k < 15; k++) begin
            idle_pct = (k < 5) ? 6 : (k < 10) ? 73 : 0;
            write_threshold((k % 3 == 2) ? 15'($urandom) : thr_set[k % 5]);
            for (int n = 0; n < N_RANDOM / 15; n++)
                send_random();
            drain();
        end

        if (sb.errors == 0 && sb.angles_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/qte_pkg.sv
rtl/core/qte_cordic.sv
rtl/core/qte_isqrt.sv
rtl/core/quaternion_to_euler_angles.sv
dv/quaternion_to_euler_angles_test.sv
